/* rtl/core/fixer_pkg.sv */
`timescale 1ns / 1ps
// types, character codes and small helpers for the fix execution report parser
// no dependencies
package fixer_pkg;

    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EIGHT = 8'h38;

    localparam logic [63:0] TAG_MSGTYPE  = 64'd35;
    localparam logic [63:0] TAG_EXECTYPE = 64'd150;
    localparam logic [63:0] TAG_ORDSTAT  = 64'd39;
    localparam logic [63:0] TAG_PRICE    = 64'd31;
    localparam logic [63:0] TAG_QTY      = 64'd32;
    localparam logic [63:0] TAG_CUMQTY   = 64'd14;
    localparam logic [63:0] TAG_SENDTIME = 64'd52;
    localparam logic [63:0] TAG_TRANTIME = 64'd60;
    localparam logic [63:0] TAG_EXECID   = 64'd17;
    localparam logic [63:0] TAG_CLORDID  = 64'd11;
    localparam logic [63:0] TAG_ORDERID  = 64'd37;

    localparam logic [1:0] KIND_ID_BYTE = 2'd0;
    localparam logic [1:0] KIND_ID_LEN  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam logic [2:0] EXEC_UNKNOWN = 3'd6;
    localparam logic [3:0] ORD_UNKNOWN  = 4'd8;

    // present flag bits
    localparam int PR_EXECID   = 0;
    localparam int PR_EXECTYPE = 1;
    localparam int PR_ORDSTAT  = 2;
    localparam int PR_PRICE    = 3;
    localparam int PR_QTY      = 4;
    localparam int PR_TIME     = 5;

    typedef struct packed {
        logic [63:0] acc;
        logic        neg;
        logic        digit;
        logic        bad;
    } t_num;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         which;
        logic [7:0]         data;
        logic [1:0]         status;
        logic [2:0]         exec_kind;
        logic [3:0]         order_state;
        logic signed [63:0] price;
        logic signed [63:0] quantity;
        logic signed [63:0] cumulative_qty;
        logic [63:0]        send_ts;
        logic [63:0]        txn_ts;
        logic               last_of_run;
    } t_res;

    // one decimal digit or a leading minus sign into an accumulator, overflow checked by shift-add
    function automatic t_num num_feed(t_num cur, logic [7:0] b, logic sgn);
        t_num        r;
        logic [3:0]  d;
        logic [67:0] prod;
        logic [63:0] lim;
        r = cur;
        if (!cur.bad) begin
            if (b == CH_MINUS) begin
                if (sgn && !cur.digit && !cur.neg) r.neg = 1'b1;
                else r.bad = 1'b1;
            end else if (b < CH_ZERO || b > CH_NINE) begin
                r.bad = 1'b1;
            end else begin
                d = 4'(b - CH_ZERO);
                if (!sgn) lim = '1;
                else if (cur.neg) lim = {1'b1, 63'd0};
                else lim = {1'b0, {63{1'b1}}};
                prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {64'd0, d};
                if (prod > {4'd0, lim}) begin
                    r.bad = 1'b1;
                end else begin
                    r.acc   = prod[63:0];
                    r.digit = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] map_exec(logic [7:0] c);
        logic [2:0] r;
        unique case (c)
            8'h30:   r = 3'd0;
            8'h31:   r = 3'd1;
            8'h32:   r = 3'd2;
            8'h34:   r = 3'd3;
            8'h35:   r = 3'd4;
            8'h38:   r = 3'd5;
            default: r = EXEC_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] map_ord(logic [7:0] c);
        logic [3:0] r;
        unique case (c)
            8'h30:   r = 4'd0;
            8'h41:   r = 4'd1;
            8'h36:   r = 4'd2;
            8'h31:   r = 4'd3;
            8'h32:   r = 4'd4;
            8'h34:   r = 4'd5;
            8'h35:   r = 4'd6;
            8'h38:   r = 4'd7;
            default: r = ORD_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/fix_exec_report_parser.sv */
`timescale 1ns / 1ps
// fix execution report parser: one message byte per request, id byte / length / summary results
// depends on fixer_pkg
//
//  channel | signals                                       | direction
//  in      | i_in_valid, o_in_ready, i_msg_byte, i_msg_end | byte requests in
//  out     | o_out_valid, i_out_ready, result fields       | results out
//
// each byte is parsed in the cycle it is accepted; its 0 to 3 results land in a
// three-entry result buffer and leave one per cycle while i_out_ready is high
// a byte with one or no result sustains one byte per cycle while i_out_ready is high;
// a byte with more results holds the input while the buffer drains
// i_rst_n (synchronous) returns the parser to tag scan and empties the buffer
module fix_exec_report_parser #(
    parameter int ID_MAX_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_msg_byte,
    input  logic               i_msg_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic [1:0]         o_id_which,
    output logic [7:0]         o_id_data,
    output logic [1:0]         o_status,
    output logic [2:0]         o_exec_kind,
    output logic [3:0]         o_order_state,
    output logic signed [63:0] o_price,
    output logic signed [63:0] o_quantity,
    output logic signed [63:0] o_cumulative_qty,
    output logic [63:0]        o_send_ts,
    output logic [63:0]        o_txn_ts,
    output logic               o_last_of_run
);
    import fixer_pkg::*;

    localparam logic [7:0] CAP = 8'(ID_MAX_BYTES);

    logic        r_in_value, n_in_value;
    t_num        r_tag, n_tag;
    t_num        r_val, n_val;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_count, n_count;
    logic        r_err, n_err;
    logic [5:0]  r_pres, n_pres;
    logic [7:0]  r_len [3];
    logic [7:0]  n_len [3];
    logic [2:0]  r_exec, n_exec;
    logic [3:0]  r_ord, n_ord;
    logic [63:0] r_num [5];
    logic [63:0] n_num [5];

    t_res        r_q [3];
    logic [1:0]  r_cnt;

    t_res        res [3];
    logic [1:0]  nres;
    logic        in_acc, out_acc;

    logic        do_fin;
    logic [63:0] t;
    logic        id_hit, num_hit, num_sgn;
    logic [1:0]  id_sel;
    logic [2:0]  num_sel;
    logic [7:0]  len;
    logic [63:0] nval;
    logic        missing;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;
    assign o_in_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign o_out_valid = (r_cnt != 2'd0);

    always_comb begin
        n_in_value = r_in_value;
        n_tag      = r_tag;
        n_val      = r_val;
        n_first    = r_first;
        n_count    = r_count;
        n_err      = r_err;
        n_pres     = r_pres;
        n_len      = r_len;
        n_exec     = r_exec;
        n_ord      = r_ord;
        n_num      = r_num;
        res[0]     = '0;
        res[1]     = '0;
        res[2]     = '0;
        nres       = 2'd0;
        do_fin     = 1'b0;
        len        = '0;
        nval       = '0;
        missing    = 1'b0;

        // tag decode from the current tag
        t       = r_tag.neg ? 64'd0 : r_tag.acc;
        id_hit  = 1'b1;
        id_sel  = 2'd0;
        if (t == TAG_EXECID) id_sel = 2'd0;
        else if (t == TAG_CLORDID) id_sel = 2'd1;
        else if (t == TAG_ORDERID) id_sel = 2'd2;
        else id_hit = 1'b0;
        num_hit = 1'b1;
        num_sel = 3'd0;
        if (t == TAG_PRICE) num_sel = 3'd0;
        else if (t == TAG_QTY) num_sel = 3'd1;
        else if (t == TAG_CUMQTY) num_sel = 3'd2;
        else if (t == TAG_SENDTIME) num_sel = 3'd3;
        else if (t == TAG_TRANTIME) num_sel = 3'd4;
        else num_hit = 1'b0;
        num_sgn = (num_sel < 3'd3);

        if (!r_err) begin
            if (!r_in_value) begin
                if (i_msg_byte == CH_EQ) begin
                    if (r_tag.bad || !r_tag.digit) n_err = 1'b1;
                    else n_in_value = 1'b1;
                end else begin
                    n_tag = num_feed(r_tag, i_msg_byte, 1'b1);
                end
            end else if (i_msg_byte == CH_SOH) begin
                do_fin = 1'b1;
            end else begin
                if (id_hit && r_count < CAP) begin
                    res[nres].kind  = KIND_ID_BYTE;
                    res[nres].which = id_sel;
                    res[nres].data  = i_msg_byte;
                    nres = nres + 2'd1;
                end
                if (num_hit) n_val = num_feed(r_val, i_msg_byte, num_sgn);
                if (r_count == 8'd0) n_first = i_msg_byte;
                if (r_count != 8'hFF) n_count = r_count + 8'd1;
            end
        end

        // a value cut off by the end of message is closed as it stands
        if (i_msg_end && !n_err && n_in_value) do_fin = 1'b1;

        if (do_fin) begin
            if (id_hit) begin
                len = (n_count < CAP) ? n_count : CAP;
                n_len[id_sel] = len;
                if (id_sel == 2'd0) n_pres[PR_EXECID] = 1'b1;
                res[nres].kind  = KIND_ID_LEN;
                res[nres].which = id_sel;
                res[nres].data  = len;
                nres = nres + 2'd1;
            end else if (num_hit) begin
                if (n_val.bad || !n_val.digit) begin
                    n_err = 1'b1;
                end else begin
                    nval = n_val.neg ? (64'd0 - n_val.acc) : n_val.acc;
                    n_num[num_sel] = nval;
                    case (num_sel)
                        3'd0:       n_pres[PR_PRICE] = 1'b1;
                        3'd1:       n_pres[PR_QTY]   = 1'b1;
                        3'd3, 3'd4: n_pres[PR_TIME]  = 1'b1;
                        default:    ;
                    endcase
                end
            end else if (t == TAG_MSGTYPE || t == TAG_EXECTYPE || t == TAG_ORDSTAT) begin
                if (n_count == 8'd0 || (t == TAG_MSGTYPE && n_first != CH_EIGHT)) begin
                    n_err = 1'b1;
                end else if (t == TAG_EXECTYPE) begin
                    n_exec = map_exec(n_first);
                    n_pres[PR_EXECTYPE] = 1'b1;
                end else if (t == TAG_ORDSTAT) begin
                    n_ord = map_ord(n_first);
                    n_pres[PR_ORDSTAT] = 1'b1;
                end
            end
            n_in_value = 1'b0;
            n_tag      = '0;
            n_val      = '0;
            n_first    = '0;
            n_count    = '0;
        end

        if (i_msg_end) begin
            res[nres].kind = KIND_SUMMARY;
            if (n_err) begin
                res[nres].status      = ST_INVALID;
                res[nres].exec_kind   = EXEC_UNKNOWN;
                res[nres].order_state = ORD_UNKNOWN;
            end else begin
                missing = (n_len[1] == 8'd0 && n_len[2] == 8'd0) || (n_pres != 6'h3F);
                res[nres].status         = missing ? ST_MISSING : ST_OK;
                res[nres].exec_kind      = n_exec;
                res[nres].order_state    = n_ord;
                res[nres].price          = n_num[0];
                res[nres].quantity       = n_num[1];
                res[nres].cumulative_qty = n_num[2];
                res[nres].send_ts        = n_num[3];
                res[nres].txn_ts         = n_num[4];
            end
            nres = nres + 2'd1;
            // per-message clear
            n_in_value = 1'b0;
            n_tag      = '0;
            n_val      = '0;
            n_first    = '0;
            n_count    = '0;
            n_err      = 1'b0;
            n_pres     = '0;
            n_len      = '{default: 8'd0};
            n_exec     = EXEC_UNKNOWN;
            n_ord      = ORD_UNKNOWN;
            n_num      = '{default: 64'd0};
        end

        if (nres != 2'd0) res[nres - 2'd1].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value <= 1'b0;
            r_tag      <= '0;
            r_val      <= '0;
            r_first    <= '0;
            r_count    <= '0;
            r_err      <= 1'b0;
            r_pres     <= '0;
            r_len      <= '{default: 8'd0};
            r_exec     <= EXEC_UNKNOWN;
            r_ord      <= ORD_UNKNOWN;
            r_num      <= '{default: 64'd0};
            r_cnt      <= 2'd0;
        end else begin
            if (in_acc) begin
                r_in_value <= n_in_value;
                r_tag      <= n_tag;
                r_val      <= n_val;
                r_first    <= n_first;
                r_count    <= n_count;
                r_err      <= n_err;
                r_pres     <= n_pres;
                r_len      <= n_len;
                r_exec     <= n_exec;
                r_ord      <= n_ord;
                r_num      <= n_num;
                r_cnt      <= nres;
            end else if (out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q <= res;
        end else if (out_acc) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    assign o_kind           = r_q[0].kind;
    assign o_id_which       = r_q[0].which;
    assign o_id_data        = r_q[0].data;
    assign o_status         = r_q[0].status;
    assign o_exec_kind      = r_q[0].exec_kind;
    assign o_order_state    = r_q[0].order_state;
    assign o_price          = r_q[0].price;
    assign o_quantity       = r_q[0].quantity;
    assign o_cumulative_qty = r_q[0].cumulative_qty;
    assign o_send_ts        = r_q[0].send_ts;
    assign o_txn_ts         = r_q[0].txn_ts;
    assign o_last_of_run    = r_q[0].last_of_run;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3 || !o_in_ready || i_out_ready)
        else $error("buffer full but input ready");
    a_end_has_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_msg_end) |=> (r_cnt != 2'd0))
        else $error("message end gave no result");
    a_last_entry_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_q[0].last_of_run)
        else $error("final buffered result lacks last mark");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cnt == 2'd0))
        else $error("buffer not empty after reset");

endmodule
